@@ sv/skvt_pkg.sv @@
// skvt_pkg: shared types, operation codes and result codes for the sorted key/value table.
// No dependencies.
package skvt_pkg;

	localparam int NAME_W = 200;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_LIST   = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_DUP   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_NF    = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] qty;
		logic [NAME_W-1:0]  name;
	} entry_t;

endpackage

@@ sv/skvt_mem.sv @@
// skvt_mem: entry store, one write port and one registered read port.
// Depends on skvt_pkg (entry_t).
module skvt_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  skvt_pkg::entry_t     wdata,
	input  logic                 re,
	input  logic [IDX_W-1:0]     raddr,
	output skvt_pkg::entry_t     rdata
);
	skvt_pkg::entry_t mem [DEPTH];
	skvt_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ sv/sorted_key_value_table_unit.sv @@
// sorted_key_value_table_unit: sorted table with insert, search, update, list.
// Depends on skvt_pkg and skvt_mem.
//
// Use: a request (operation, part_key, amount, name words) is taken on the
// req channel when req_valid is high and req_stall low. Results leave on the
// rsp channel under rsp_valid / rsp_stall; last marks the final result of a
// request. Insert, search and update give one result, list gives one per
// stored entry (or one "empty" result).
// Flow: entries sit in one memory with a registered read port. The linear key
// scan visits each entry in a read state and a compare state; an insert shifts
// the tail up, reading each moved entry and writing it one slot higher, then
// writes the new slot. List reads each entry and emits it when the output
// register is free.
// Only one request is worked on at a time: req_stall is high while busy.
// Reset clears the entry count, so the table is empty; memory is not cleared.
// A stalled result holds in the output register; the engine waits on it.
module sorted_key_value_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] part_key,
	input  logic signed [31:0] amount,
	input  logic [63:0]        name_word0,
	input  logic [63:0]        name_word1,
	input  logic [63:0]        name_word2,
	input  logic [7:0]         name_tail,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [31:0] entry_key,
	output logic signed [31:0] entry_quantity,
	output logic [63:0]        entry_name0,
	output logic [63:0]        entry_name1,
	output logic [63:0]        entry_name2,
	output logic [7:0]         entry_name_tail,
	output logic               last
);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	// controller states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRD   = 3'd1; // scan: read slot
	localparam logic [2:0] S_SCMP  = 3'd2; // scan: compare key
	localparam logic [2:0] S_SHRD  = 3'd3; // shift: read slot below
	localparam logic [2:0] S_SHWR  = 3'd4; // shift: write one up
	localparam logic [2:0] S_FIN   = 3'd5; // write new entry
	localparam logic [2:0] S_RES   = 3'd6; // hand single result to output
	localparam logic [2:0] S_LRD   = 3'd7; // list: read / emit

	logic [2:0]       state_q;
	logic             lemit_q;   // list: read data ready, emit pending
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] slot_q;

	logic [1:0]         op_q;
	logic signed [31:0] amt_q;
	skvt_pkg::entry_t   new_q;

	logic [2:0]         res_status_q;
	skvt_pkg::entry_t   res_entry_q;

	logic               out_valid_q;
	logic [2:0]         out_status_q;
	skvt_pkg::entry_t   out_entry_q;
	logic               out_last_q;

	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	skvt_pkg::entry_t   mem_wdata, rdata;

	logic               out_free;
	logic               req_take;
	logic signed [32:0] sum;
	logic signed [31:0] sat_qty;
	logic [CNT_W-1:0]   idx_dec;

	skvt_mem #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign idx_dec   = idx_q - CNT_W'(1);

	// saturating add of the update amount
	assign sum = {rdata.qty[31], rdata.qty} + {amt_q[31], amt_q};
	always_comb begin
		if (sum[32] != sum[31]) begin
			sat_qty = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat_qty = sum[31:0];
		end
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_raddr = idx_q[IDX_W-1:0];
		mem_wdata = rdata;
		case (state_q)
			S_SRD: begin
				mem_re = (idx_q != cnt_q);
			end
			S_SCMP: begin
				mem_we        = (op_q == skvt_pkg::OP_UPDATE) && (rdata.key == new_q.key);
				mem_wdata.qty = sat_qty;
			end
			S_SHRD: begin
				mem_re    = (idx_q != slot_q);
				mem_raddr = idx_dec[IDX_W-1:0];
			end
			S_SHWR: begin
				mem_we = 1'b1;
			end
			S_FIN: begin
				mem_we    = 1'b1;
				mem_waddr = slot_q[IDX_W-1:0];
				mem_wdata = new_q;
			end
			S_LRD: begin
				mem_re = !lemit_q;
			end
			default: begin
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_take) begin
			op_q         <= operation;
			amt_q        <= amount;
			new_q.key    <= part_key;
			new_q.qty    <= amount;
			new_q.name   <= {name_tail, name_word2, name_word1, name_word0};
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lemit_q <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			slot_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						idx_q <= '0;
						if (operation == skvt_pkg::OP_LIST) begin
							state_q <= (cnt_q == '0) ? S_RES : S_LRD;
							lemit_q <= 1'b0;
						end else if (operation == skvt_pkg::OP_INSERT && cnt_q == DEPTH_C) begin
							state_q <= S_RES;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (idx_q == cnt_q) begin
						if (op_q == skvt_pkg::OP_INSERT) begin
							slot_q  <= idx_q;
							state_q <= S_SHRD;
						end else begin
							state_q <= S_RES;
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (rdata.key >= new_q.key) begin
						if (op_q == skvt_pkg::OP_INSERT && rdata.key != new_q.key) begin
							slot_q  <= idx_q;
							idx_q   <= cnt_q;
							state_q <= S_SHRD;
						end else begin
							state_q <= S_RES;
						end
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_SRD;
					end
				end
				S_SHRD: begin
					state_q <= (idx_q == slot_q) ? S_FIN : S_SHWR;
				end
				S_SHWR: begin
					idx_q   <= idx_dec;
					state_q <= S_SHRD;
				end
				S_FIN: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LRD: begin
					if (!lemit_q) begin
						lemit_q <= 1'b1;
					end else if (out_free) begin
						lemit_q <= 1'b0;
						if (idx_q + CNT_W'(1) == cnt_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// single-result staging
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_status_q          <= (operation == skvt_pkg::OP_LIST) ?
					skvt_pkg::ST_EMPTY : skvt_pkg::ST_FULL;
				res_entry_q.key       <= (operation != skvt_pkg::OP_LIST) ? part_key : '0;
				res_entry_q.qty       <= '0;
				res_entry_q.name      <= '0;
			end
			S_SRD: begin
				res_status_q <= skvt_pkg::ST_NF;
			end
			S_SCMP: begin
				if (rdata.key == new_q.key) begin
					res_status_q <= (op_q == skvt_pkg::OP_INSERT) ?
						skvt_pkg::ST_DUP : skvt_pkg::ST_OK;
					res_entry_q.key  <= rdata.key;
					res_entry_q.name <= rdata.name;
					res_entry_q.qty  <= (op_q == skvt_pkg::OP_UPDATE) ? sat_qty : rdata.qty;
				end else begin
					res_status_q <= skvt_pkg::ST_NF;
				end
			end
			S_FIN: begin
				res_status_q <= skvt_pkg::ST_OK;
				res_entry_q  <= new_q;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RES && out_free) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_LRD && lemit_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			out_last_q   <= 1'b1;
		end else if (state_q == S_LRD && lemit_q && out_free) begin
			out_status_q <= skvt_pkg::ST_OK;
			out_entry_q  <= rdata;
			out_last_q   <= (idx_q + CNT_W'(1) == cnt_q);
		end
	end

	assign rsp_valid       = out_valid_q;
	assign status          = out_status_q;
	assign entry_key       = out_entry_q.key;
	assign entry_quantity  = out_entry_q.qty;
	assign entry_name0     = out_entry_q.name[63:0];
	assign entry_name1     = out_entry_q.name[127:64];
	assign entry_name2     = out_entry_q.name[191:128];
	assign entry_name_tail = out_entry_q.name[199:192];
	assign last            = out_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count above table depth");

	a_fin_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the table");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q != S_IDLE)
		else $error("request taken without leaving idle");
`endif
endmodule

@@ test/skvt_checker.sv @@
// skvt_checker: watches the request and result channels of the sorted table,
// predicts results from its own copy of the table and compares them.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
module skvt_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] part_key,
	input  logic signed [31:0] amount,
	input  logic [63:0]        name_word0,
	input  logic [63:0]        name_word1,
	input  logic [63:0]        name_word2,
	input  logic [7:0]         name_tail,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [2:0]         status,
	input  logic signed [31:0] entry_key,
	input  logic signed [31:0] entry_quantity,
	input  logic [63:0]        entry_name0,
	input  logic [63:0]        entry_name1,
	input  logic [63:0]        entry_name2,
	input  logic [7:0]         entry_name_tail,
	input  logic               last,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count
);
	typedef struct packed {
		logic [2:0]                  st;
		logic signed [31:0]          key;
		logic signed [31:0]          qty;
		logic [skvt_pkg::NAME_W-1:0] name;
		logic                        lst;
	} table_result_t;

	skvt_pkg::entry_t shadow_table [TABLE_DEPTH];
	int               shadow_count;
	table_result_t    expected_results [$];

	assign pending = expected_results.size();

	function automatic table_result_t make_result(logic [2:0] st, logic signed [31:0] k,
			logic signed [31:0] q, logic [skvt_pkg::NAME_W-1:0] n, logic l);
		table_result_t r;
		r.st = st; r.key = k; r.qty = q; r.name = n; r.lst = l;
		return r;
	endfunction

	task automatic apply_request();
		int s;
		int i;
		longint q;
		logic [skvt_pkg::NAME_W-1:0] nm;
		nm = {name_tail, name_word2, name_word1, name_word0};
		s = 0;
		while (s < shadow_count && shadow_table[s].key < part_key)
			s++;
		case (operation)
			skvt_pkg::OP_INSERT: begin
				if (shadow_count >= TABLE_DEPTH) begin
					expected_results.push_back(make_result(skvt_pkg::ST_FULL, part_key,
						0, '0, 1'b1));
				end else if (s < shadow_count && shadow_table[s].key == part_key) begin
					expected_results.push_back(make_result(skvt_pkg::ST_DUP,
						shadow_table[s].key, shadow_table[s].qty, shadow_table[s].name,
						1'b1));
				end else begin
					for (i = shadow_count; i > s; i--)
						shadow_table[i] = shadow_table[i-1];
					shadow_table[s].key = part_key;
					shadow_table[s].qty = amount;
					shadow_table[s].name = nm;
					shadow_count++;
					expected_results.push_back(make_result(skvt_pkg::ST_OK, part_key,
						amount, nm, 1'b1));
				end
			end
			skvt_pkg::OP_SEARCH, skvt_pkg::OP_UPDATE: begin
				if (s < shadow_count && shadow_table[s].key == part_key) begin
					if (operation == skvt_pkg::OP_UPDATE) begin
						q = longint'(shadow_table[s].qty) + longint'(amount);
						if (q > 64'sd2147483647) q = 64'sd2147483647;
						if (q < -64'sd2147483648) q = -64'sd2147483648;
						shadow_table[s].qty = q[31:0];
					end
					expected_results.push_back(make_result(skvt_pkg::ST_OK,
						shadow_table[s].key, shadow_table[s].qty, shadow_table[s].name,
						1'b1));
				end else begin
					expected_results.push_back(make_result(skvt_pkg::ST_NF, part_key,
						0, '0, 1'b1));
				end
			end
			default: begin
				if (shadow_count == 0)
					expected_results.push_back(make_result(skvt_pkg::ST_EMPTY, 0, 0,
						'0, 1'b1));
				for (i = 0; i < shadow_count; i++)
					expected_results.push_back(make_result(skvt_pkg::ST_OK,
						shadow_table[i].key, shadow_table[i].qty, shadow_table[i].name,
						i + 1 == shadow_count));
			end
		endcase
	endtask

	task automatic compare_result();
		table_result_t e;
		if (expected_results.size() == 0) begin
			$error("unexpected result: status %0d key %0d", status, entry_key);
			fail_count++;
			return;
		end
		e = expected_results.pop_front();
		if (status !== e.st) begin
			$error("status: expected %0d, actual %0d", e.st, status); fail_count++;
		end
		if (entry_key !== e.key) begin
			$error("entry_key: expected %0d, actual %0d", e.key, entry_key); fail_count++;
		end
		if (entry_quantity !== e.qty) begin
			$error("entry_quantity: expected %0d, actual %0d", e.qty, entry_quantity);
			fail_count++;
		end
		if (entry_name0 !== e.name[63:0]) begin
			$error("entry_name0: expected %h, actual %h", e.name[63:0], entry_name0);
			fail_count++;
		end
		if (entry_name1 !== e.name[127:64]) begin
			$error("entry_name1: expected %h, actual %h", e.name[127:64], entry_name1);
			fail_count++;
		end
		if (entry_name2 !== e.name[191:128]) begin
			$error("entry_name2: expected %h, actual %h", e.name[191:128], entry_name2);
			fail_count++;
		end
		if (entry_name_tail !== e.name[199:192]) begin
			$error("entry_name_tail: expected %h, actual %h", e.name[199:192],
				entry_name_tail);
			fail_count++;
		end
		if (last !== e.lst) begin
			$error("last: expected %0d, actual %0d", e.lst, last); fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			fail_count = 0;
			result_count = 0;
			expected_results.delete();
		end else begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				compare_result();
				result_count++;
			end
			if (req_valid === 1'b1 && req_stall === 1'b0)
				apply_request();
		end
	end
endmodule

@@ test/tb_sorted_key_value_table_unit.sv @@
// tb_sorted_key_value_table_unit: stimulus and verdict for the sorted table.
// Depends on skvt_pkg, sorted_key_value_table_unit and skvt_checker.
`timescale 1ns / 1ps
module tb_sorted_key_value_table_unit;
	localparam int DEPTH = 64;
	// Worst request: a scan or shift over the whole table, plus stalls on up to 64 results.
	localparam longint CYCLE_LIMIT = 1000000;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         operation;
	logic signed [31:0] part_key;
	logic signed [31:0] amount;
	logic [63:0]        name_word0;
	logic [63:0]        name_word1;
	logic [63:0]        name_word2;
	logic [7:0]         name_tail;
	logic               rsp_valid;
	logic               rsp_stall;
	logic [2:0]         status;
	logic signed [31:0] entry_key;
	logic signed [31:0] entry_quantity;
	logic [63:0]        entry_name0;
	logic [63:0]        entry_name1;
	logic [63:0]        entry_name2;
	logic [7:0]         entry_name_tail;
	logic               last;
	int                 fail_count;
	int                 pending;
	int                 result_count;
	longint             cycle_count;
	bit                 calm;	// stretch with no idling on either side
	int                 request_count;
	logic signed [31:0] used_keys [$];

	sorted_key_value_table_unit #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

	skvt_checker #(.TABLE_DEPTH(DEPTH)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter doubles as the watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sorted_key_value_table_unit: FAIL");
			$finish;
		end
	end

	// Result side stalls ~31% of cycles except during the calm stretch.
	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 31);
	end

	// Drive one request and hold it until accepted.
	task automatic send_request(logic [1:0] op, logic signed [31:0] k,
			logic signed [31:0] a, logic [skvt_pkg::NAME_W-1:0] nm);
		while (!calm && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		operation  <= op;
		part_key   <= k;
		amount     <= a;
		name_word0 <= nm[63:0];
		name_word1 <= nm[127:64];
		name_word2 <= nm[191:128];
		name_tail  <= nm[199:192];
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		request_count++;
		if (op == skvt_pkg::OP_INSERT)
			used_keys.push_back(k);
	endtask

	function automatic logic [skvt_pkg::NAME_W-1:0] rand_name();
		logic [skvt_pkg::NAME_W-1:0] n;
		for (int i = 0; i < skvt_pkg::NAME_W / 8; i++)
			n[i*8 +: 8] = 8'($urandom);
		return n;
	endfunction

	function automatic logic signed [31:0] pick_key();
		if (used_keys.size() > 0 && $urandom_range(99) < 60)
			return used_keys[$urandom_range(used_keys.size() - 1)];
		return $urandom_range(3) == 0 ? $urandom : $urandom_range(40) - 20;
	endfunction

	initial begin
		logic [1:0] op;
		int r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_stall = 1'b0;
		operation = skvt_pkg::OP_INSERT;
		part_key = '0; amount = '0;
		name_word0 = '0; name_word1 = '0; name_word2 = '0; name_tail = '0;
		cycle_count = 0;
		calm = 1'b0;
		request_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, misses, extreme keys, duplicate, saturation.
		send_request(skvt_pkg::OP_LIST, 0, 0, '0);
		send_request(skvt_pkg::OP_SEARCH, 5, 0, '0);
		send_request(skvt_pkg::OP_UPDATE, 5, 1, '0);
		send_request(skvt_pkg::OP_INSERT, 32'sh7fffffff, 32'sh7fffffff, '1);
		send_request(skvt_pkg::OP_INSERT, 32'sh80000000, 32'sh80000000, '0);
		send_request(skvt_pkg::OP_INSERT, 0, -1, rand_name());
		send_request(skvt_pkg::OP_INSERT, 0, 7, rand_name());
		send_request(skvt_pkg::OP_UPDATE, 32'sh7fffffff, 1, '0);
		send_request(skvt_pkg::OP_UPDATE, 32'sh80000000, -1, '0);
		send_request(skvt_pkg::OP_UPDATE, 0, 32'sh80000000, '0);
		send_request(skvt_pkg::OP_UPDATE, 0, 32'sh80000000, '0);
		send_request(skvt_pkg::OP_SEARCH, 32'sh7fffffff, 0, '0);
		send_request(skvt_pkg::OP_SEARCH, 1, 0, '0);
		send_request(skvt_pkg::OP_LIST, 0, 0, '0);

		// Random: mostly inserts/lookups on a small key pool, then a fill to full.
		for (int n = 0; n < 20; n++) begin
			r = $urandom_range(99);
			op = r < 40 ? skvt_pkg::OP_INSERT : r < 60 ? skvt_pkg::OP_SEARCH :
				r < 85 ? skvt_pkg::OP_UPDATE : skvt_pkg::OP_LIST;
			send_request(op, pick_key(), $urandom, rand_name());
		end
		for (int n = 0; n < 64; n++) begin
			calm = (n >= 10 && n < 40);
			send_request(skvt_pkg::OP_INSERT, $urandom, $urandom, rand_name());
		end
		calm = 1'b0;
		send_request(skvt_pkg::OP_INSERT, 32'sh7fffffff, 0, '0);
		send_request(skvt_pkg::OP_LIST, 0, 0, '0);
		req_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (4 * DEPTH + 8) @(posedge clk);
		$display("Sent %0d requests and checked %0d results, table filled to capacity.",
			request_count, result_count);
		if (fail_count == 0 && pending == 0)
			$display("tb_sorted_key_value_table_unit: PASS");
		else
			$display("tb_sorted_key_value_table_unit: FAIL");
		$finish;
	end
endmodule

@@ sorted_key_value_table_unit.f @@
sv/skvt_pkg.sv
sv/skvt_mem.sv
sv/sorted_key_value_table_unit.sv
test/skvt_checker.sv
test/tb_sorted_key_value_table_unit.sv
